>>> design/smm_pkg.sv
package smm_pkg;

    localparam int ELEMENT_W = 32;
    localparam int PRODUCT_W = 32;
    localparam int CFG_W     = 4;

    localparam logic [CFG_W-1:0] MATRIX_SIZE_RESET = 4'd8;

    typedef enum logic
    {
        CMD_LOAD_A = 1'b0,
        CMD_LOAD_B = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // One multiply-accumulate beat travelling alongside the store read data
    typedef struct packed
    {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

>>> design/smm_load_if.sv
interface smm_load_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [smm_pkg::ELEMENT_W-1:0]  element;

    modport source (output valid, output command, output element, input ready);
    modport sink   (input valid, input command, input element, output ready);
endinterface

>>> design/smm_result_if.sv
interface smm_result_if;
    logic                           valid;
    logic                           ready;
    logic [smm_pkg::PRODUCT_W-1:0]  product;
    logic                           last;

    modport source (output valid, output product, output last, input ready);
    modport sink   (input valid, input product, input last, output ready);
endinterface

>>> design/smm_cfg_if.sv
interface smm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [smm_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/smm_ram.sv
module smm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/smm_mac.sv
module smm_mac (
    input  logic                           clk,
    input  logic                           rst_n,
    input  smm_pkg::mac_ctl_t              ctl,
    input  logic [smm_pkg::ELEMENT_W-1:0]  a,
    input  logic [smm_pkg::ELEMENT_W-1:0]  b,
    output logic [smm_pkg::PRODUCT_W-1:0]  acc,
    output logic                           done
);

    logic [smm_pkg::PRODUCT_W-1:0]   full_prod;
    logic [smm_pkg::PRODUCT_W-1:0]   prod_reg;
    smm_pkg::mac_ctl_t               ctl_reg;
    logic [smm_pkg::PRODUCT_W-1:0]   acc_reg;
    logic [smm_pkg::PRODUCT_W-1:0]   acc_next;
    logic                            done_reg;

    // Low word of the product only
    assign full_prod = a * b;

    // Restart the sum on the first term, keep the low word only
    assign acc_next = ctl_reg.first ? prod_reg : acc_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod;
        if (ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            done_reg <= ctl_reg.valid & ctl_reg.last;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

>>> design/square_matrix_multiply.sv
// Square matrix multiplier, C = A * B on unsigned 32-bit words, modulo 2^32.
// Channels:
//   load   - one element per transfer; command 0 stores the next element of A,
//            command 1 the next element of B, both in row-major order.
//   result - the elements of C in row-major order, last high on the final one.
//   cfg    - writes matrix_size (n); 0 acts as 1, values above MAX_SIZE act as
//            MAX_SIZE. A write also rewinds both load counters. Write only
//            while the block is idle.
// Timing: the transfer that completes B starts the computation; load stays low
// until the final result has been handed to the output register. One shared
// multiply-accumulate unit reads one A and one B term per cycle while a dot
// product runs, so each result takes n reads and then passes through the store
// read, multiply and accumulate stages.
// A stalled receiver holds the current result in the output register; the
// next dot product waits until that register frees up.
// Reset clears the load counters and sets matrix_size to 8. The A and B
// stores are not cleared; read only entries loaded since reset.
module square_matrix_multiply #(
    parameter int MAX_SIZE = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    smm_load_if.sink     load,
    smm_result_if.source result,
    smm_cfg_if.sink      cfg
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SIZE_W = $clog2(MAX_SIZE + 1);
    localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

    // Configuration and load bookkeeping
    logic [smm_pkg::CFG_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0]         n;
    logic [SIZE_W-1:0]         n_m1;
    logic [CNT_W-1:0]          total;
    logic [CNT_W-1:0]          a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]          b_cnt_reg, b_cnt_next;
    logic [CNT_W-1:0]          b_slot;
    logic [CNT_W-1:0]          b_slot_plus;
    logic                      cfg_fire;
    logic                      load_fire;
    logic                      a_we;
    logic                      b_we;
    logic                      start;

    // Sequencer
    smm_pkg::state_t           state_reg, state_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [IDX_W-1:0]          k_reg, k_next;
    logic [ADDR_W-1:0]         a_row_reg, a_row_next;
    logic [ADDR_W-1:0]         a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0]         b_addr_reg, b_addr_next;
    logic                      issue;
    logic                      k_last;
    logic                      j_last;
    logic                      elem_last;
    logic                      load_out;
    smm_pkg::mac_ctl_t         iss_reg, iss_next;

    // Datapath and output register
    logic [smm_pkg::ELEMENT_W-1:0] a_q;
    logic [smm_pkg::ELEMENT_W-1:0] b_q;
    logic [smm_pkg::PRODUCT_W-1:0] acc;
    logic                          mac_done;
    logic                          done_reg, done_next;
    logic                          out_valid_reg, out_valid_next;
    logic [smm_pkg::PRODUCT_W-1:0] out_product_reg;
    logic                          out_last_reg;

    // Clamp matrix_size into 1..MAX_SIZE
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            n = SIZE_W'(1);
        end
        else if (int'(size_reg) > MAX_SIZE)
        begin
            n = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            n = SIZE_W'(size_reg);
        end
    end

    assign n_m1  = n - SIZE_W'(1);
    assign total = CNT_W'(n) * CNT_W'(n);

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;
    assign load_fire = load.valid & load.ready;

    // A full B store rewinds to its first slot
    assign b_slot      = (b_cnt_reg >= total) ? '0 : b_cnt_reg;
    assign b_slot_plus = b_slot + CNT_W'(1);

    always_comb
    begin
        size_next  = size_reg;
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        a_we       = 1'b0;
        b_we       = 1'b0;
        start      = 1'b0;
        if (cfg_fire)
        begin
            size_next  = cfg.data;
            a_cnt_next = '0;
            b_cnt_next = '0;
        end
        else if (load_fire)
        begin
            if (load.command == smm_pkg::CMD_LOAD_A)
            begin
                // Drop A elements beyond n*n
                if (a_cnt_reg < total)
                begin
                    a_we       = 1'b1;
                    a_cnt_next = a_cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                b_we = 1'b1;
                if (b_slot_plus == total)
                begin
                    start      = 1'b1;
                    a_cnt_next = '0;
                    b_cnt_next = '0;
                end
                else
                begin
                    b_cnt_next = b_slot_plus;
                end
            end
        end
    end

    smm_ram #(
        .WIDTH (smm_pkg::ELEMENT_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (a_cnt_reg[ADDR_W-1:0]),
        .wr_data (load.element),
        .rd_en   (issue),
        .rd_addr (a_addr_reg),
        .rd_data (a_q)
    );

    smm_ram #(
        .WIDTH (smm_pkg::ELEMENT_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (b_slot[ADDR_W-1:0]),
        .wr_data (load.element),
        .rd_en   (issue),
        .rd_addr (b_addr_reg),
        .rd_data (b_q)
    );

    assign k_last    = (k_reg == IDX_W'(n_m1));
    assign j_last    = (j_reg == IDX_W'(n_m1));
    assign elem_last = j_last & (i_reg == IDX_W'(n_m1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = smm_pkg::ST_RUN;
                end
            end
            smm_pkg::ST_RUN:
            begin
                if (k_last)
                begin
                    state_next = smm_pkg::ST_DRAIN;
                end
            end
            smm_pkg::ST_DRAIN:
            begin
                if (load_out)
                begin
                    state_next = elem_last ? smm_pkg::ST_IDLE : smm_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = smm_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        load.ready = 1'b0;
        issue      = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            smm_pkg::ST_IDLE:
            begin
                load.ready = 1'b1;
            end
            smm_pkg::ST_RUN:
            begin
                issue = 1'b1;
            end
            smm_pkg::ST_DRAIN:
            begin
                // Move the finished sum out once the output register is free
                load_out = (done_reg | mac_done) & (~out_valid_reg | result.ready);
            end
            default:
            begin
                load.ready = 1'b0;
            end
        endcase
    end

    // Index and address stepping: A walks along row i, B down column j
    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_row_next  = a_row_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        if (start)
        begin
            i_next      = '0;
            j_next      = '0;
            k_next      = '0;
            a_row_next  = '0;
            a_addr_next = '0;
            b_addr_next = '0;
        end
        else if (issue)
        begin
            if (k_last)
            begin
                k_next = '0;
            end
            else
            begin
                k_next      = k_reg + IDX_W'(1);
                a_addr_next = a_addr_reg + ADDR_W'(1);
                b_addr_next = b_addr_reg + ADDR_W'(n);
            end
        end
        else if (load_out && !elem_last)
        begin
            if (j_last)
            begin
                j_next      = '0;
                i_next      = i_reg + IDX_W'(1);
                a_row_next  = a_row_reg + ADDR_W'(n);
                a_addr_next = a_row_reg + ADDR_W'(n);
                b_addr_next = '0;
            end
            else
            begin
                j_next      = j_reg + IDX_W'(1);
                a_addr_next = a_row_reg;
                b_addr_next = ADDR_W'(j_reg) + ADDR_W'(1);
            end
        end
    end

    // Align the beat flags with the registered store read data
    always_comb
    begin
        iss_next.valid = issue;
        iss_next.first = (k_reg == '0);
        iss_next.last  = k_last;
    end

    smm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (iss_reg),
        .a     (a_q),
        .b     (b_q),
        .acc   (acc),
        .done  (mac_done)
    );

    // Hold the finished sum flag until the output register takes it
    assign done_next = load_out ? 1'b0 : (done_reg | mac_done);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= smm_pkg::MATRIX_SIZE_RESET;
            a_cnt_reg     <= '0;
            b_cnt_reg     <= '0;
            state_reg     <= smm_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            iss_reg       <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            a_cnt_reg     <= a_cnt_next;
            b_cnt_reg     <= b_cnt_next;
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            iss_reg       <= iss_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_row_reg  <= a_row_next;
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        if (load_out)
        begin
            out_product_reg <= acc;
            out_last_reg    <= elem_last;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.product = out_product_reg;
    assign result.last    = out_last_reg;

endmodule

>>> dv/testbench.sv
module testbench;

    localparam int MAX_DIM         = 8;
    localparam int STORE_DEPTH     = MAX_DIM * MAX_DIM;
    localparam int STORE_AW        = $clog2(STORE_DEPTH);
    localparam int SIZE_W          = smm_pkg::CFG_W;
    localparam int ITEM_TARGET     = 470;
    localparam int MAX_WAIT        = 19;
    // Leave room for the last result to pass through the pipeline after the queue drains
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    // Longest quiet stretch of a correct run is the hold-off; take it many times over
    localparam int STALL_LIMIT     = 4000;
    localparam int PRINT_LIMIT     = 100;

    // Predicts C = A * B from the transfers seen on the load and cfg channels
    class product_scoreboard;
        logic [smm_pkg::ELEMENT_W-1:0] a_store [STORE_DEPTH];
        logic [smm_pkg::ELEMENT_W-1:0] b_store [STORE_DEPTH];
        bit                            a_written [STORE_DEPTH];
        int unsigned                   a_count;
        int unsigned                   b_count;
        logic [smm_pkg::CFG_W-1:0]     size_reg;
        logic [smm_pkg::PRODUCT_W-1:0] expected_product [$];
        logic                          expected_last [$];
        int unsigned                   loads_used;
        int unsigned                   errors;

        function new();
            size_reg   = smm_pkg::MATRIX_SIZE_RESET;
            a_count    = 0;
            b_count    = 0;
            loads_used = 0;
            errors     = 0;
            foreach (a_written[idx])
                a_written[idx] = 1'b0;
        endfunction

        function int unsigned dim();
            int unsigned n;
            n = 32'(size_reg);
            if (n == 0)
                n = 1;
            if (n > MAX_DIM)
                n = MAX_DIM;
            return n;
        endfunction

        function int unsigned pending();
            return expected_product.size();
        endfunction

        function void note_size(logic [smm_pkg::CFG_W-1:0] value);
            size_reg = value;
            a_count  = 0;
            b_count  = 0;
        endfunction

        // True when the next B would start a product that reads A entries never loaded
        function bit b_completes_blind();
            int unsigned total;
            int unsigned next_b;
            total  = dim() * dim();
            next_b = (b_count >= total) ? 1 : b_count + 1;
            if (next_b < total)
                return 1'b0;
            for (int unsigned idx = 0; idx < total; idx++)
                if (!a_written[STORE_AW'(idx)])
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_load(smm_pkg::cmd_t cmd, logic [smm_pkg::ELEMENT_W-1:0] value);
            int unsigned                   n;
            int unsigned                   total;
            logic [smm_pkg::PRODUCT_W-1:0] acc;
            logic [smm_pkg::PRODUCT_W-1:0] term;
            n     = dim();
            total = n * n;
            if (cmd == smm_pkg::CMD_LOAD_A)
            begin
                if (a_count < total)
                begin
                    a_store[STORE_AW'(a_count)]   = value;
                    a_written[STORE_AW'(a_count)] = 1'b1;
                    a_count++;
                    loads_used++;
                end
                return;
            end
            loads_used++;
            if (b_count >= total)
                b_count = 0;
            b_store[STORE_AW'(b_count)] = value;
            b_count++;
            if (b_count < total)
                return;
            for (int unsigned i = 0; i < n; i++)
            begin
                for (int unsigned j = 0; j < n; j++)
                begin
                    acc = '0;
                    for (int unsigned k = 0; k < n; k++)
                    begin
                        term = a_store[STORE_AW'(i * n + k)] * b_store[STORE_AW'(k * n + j)];
                        acc  = acc + term;
                    end
                    expected_product.push_back(acc);
                    expected_last.push_back((i == n - 1) && (j == n - 1));
                end
            end
            a_count = 0;
            b_count = 0;
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("ERROR at %0t: %s", $realtime, what);
        endtask

        task check_result(logic [smm_pkg::PRODUCT_W-1:0] product, logic last_flag);
            logic [smm_pkg::PRODUCT_W-1:0] want_product;
            logic                          want_last;
            if (expected_product.size() == 0)
            begin
                report_mismatch($sformatf("result %h with no product pending", product));
                return;
            end
            want_product = expected_product.pop_front();
            want_last    = expected_last.pop_front();
            if (product !== want_product)
                report_mismatch($sformatf("product %h, predicted %h", product, want_product));
            if (last_flag !== want_last)
                report_mismatch($sformatf("last %b, predicted %b", last_flag, want_last));
        endtask

        task flag_leftovers();
            while (expected_product.size() != 0)
            begin
                report_mismatch($sformatf("product %h never arrived",
                                          expected_product.pop_front()));
                void'(expected_last.pop_front());
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    smm_load_if   ld_if ();
    smm_result_if res_if ();
    smm_cfg_if    cfg_if ();

    square_matrix_multiply #(
        .MAX_SIZE (MAX_DIM)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (ld_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    product_scoreboard product_sb = new();

    // Hold-off request from the stimulus, served by the result process
    int unsigned hold_cycles = 0;
    bit          send_burst  = 1'b0;
    bit          recv_burst  = 1'b0;
    int unsigned idle_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly random words, with the all-zero, all-one and one-hot words mixed in
    function automatic logic [smm_pkg::ELEMENT_W-1:0] pick_element();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    // Drive one load transfer; idle a random number of cycles first unless in a burst.
    // Keep valid high straight into the next item when there is no gap.
    task automatic drive_load(smm_pkg::cmd_t cmd, logic [smm_pkg::ELEMENT_W-1:0] value);
        int unsigned gap;
        if ($urandom_range(0, 15) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0)
        begin
            ld_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ld_if.valid   <= 1'b1;
        ld_if.command <= cmd;
        ld_if.element <= value;
        do @(posedge clk); while (!(ld_if.valid && ld_if.ready));
        product_sb.note_load(cmd, value);
    endtask

    // A product may only read A entries loaded since reset: top up A before a B
    // that would complete the matrix while some entry in use was never loaded.
    task automatic send_item(smm_pkg::cmd_t cmd, logic [smm_pkg::ELEMENT_W-1:0] value);
        if (cmd == smm_pkg::CMD_LOAD_B)
            while (product_sb.b_completes_blind())
                drive_load(smm_pkg::CMD_LOAD_A, pick_element());
        drive_load(cmd, value);
    endtask

    // Write matrix_size only once the block is idle: drop the load valid, wait for
    // every predicted product, then give the pipeline time to empty.
    task automatic change_size(logic [smm_pkg::CFG_W-1:0] value);
        ld_if.valid <= 1'b0;
        while (product_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
        product_sb.note_size(value);
    endtask

    // One load sequence at the current size: mostly a clean A then B pair,
    // sometimes random commands, surplus A words, or a short A before a full B.
    task automatic run_sequence();
        int unsigned total;
        int unsigned shape;
        int unsigned count;
        total = product_sb.dim() * product_sb.dim();
        shape = $urandom_range(0, 9);
        if (shape == 7)
        begin
            count = $urandom_range(1, 2 * total);
            repeat (count) send_item(smm_pkg::cmd_t'($urandom_range(0, 1)), pick_element());
        end
        else
        begin
            if (shape == 8)
                count = total + $urandom_range(1, 3);
            else if (shape == 9)
                count = $urandom_range(0, total - 1);
            else
                count = total;
            repeat (count) send_item(smm_pkg::CMD_LOAD_A, pick_element());
            repeat (total) send_item(smm_pkg::CMD_LOAD_B, pick_element());
        end
    endtask

    // Result side: stall a random number of cycles before each transfer, serve any
    // hold-off request by counting it down here, then check the transfer.
    initial
    begin
        int unsigned gap;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (hold_cycles != 0)
            begin
                gap         = gap + hold_cycles;
                hold_cycles = 0;
            end
            if (gap != 0)
            begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!(res_if.valid && res_if.ready));
            product_sb.check_result(res_if.product, res_if.last);
        end
    end

    // Watchdog: end the run when no channel moves a transfer for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((ld_if.valid && ld_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int unsigned               phase;
        int unsigned               pairs;
        logic [smm_pkg::CFG_W-1:0] size_val;

        rst_n          = 1'b0;
        ld_if.valid    = 1'b0;
        ld_if.command  = smm_pkg::CMD_LOAD_A;
        ld_if.element  = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Size zero acts as one; the second A word is past the end and dropped
        change_size(4'd0);
        send_item(smm_pkg::CMD_LOAD_A, 32'hFFFF_FFFF);
        send_item(smm_pkg::CMD_LOAD_A, 32'h0000_0000);
        send_item(smm_pkg::CMD_LOAD_B, 32'hFFFF_FFFF);

        // 2x2 with extreme words so products and sums wrap
        change_size(4'd2);
        send_item(smm_pkg::CMD_LOAD_A, 32'h0000_0000);
        send_item(smm_pkg::CMD_LOAD_A, 32'hFFFF_FFFF);
        send_item(smm_pkg::CMD_LOAD_A, 32'h8000_0000);
        send_item(smm_pkg::CMD_LOAD_A, 32'h0000_0001);
        send_item(smm_pkg::CMD_LOAD_B, 32'hFFFF_FFFF);
        send_item(smm_pkg::CMD_LOAD_B, 32'h0000_0002);
        send_item(smm_pkg::CMD_LOAD_B, 32'h7FFF_FFFF);
        send_item(smm_pkg::CMD_LOAD_B, 32'h8000_0000);

        // B completes before A: only the first A word is fresh, the rest are kept
        send_item(smm_pkg::CMD_LOAD_A, 32'h0000_0003);
        repeat (4) send_item(smm_pkg::CMD_LOAD_B, pick_element());

        // A size write in the middle of a load rewinds both counters
        send_item(smm_pkg::CMD_LOAD_A, 32'hDEAD_BEEF);
        send_item(smm_pkg::CMD_LOAD_A, 32'h1234_5678);
        send_item(smm_pkg::CMD_LOAD_B, 32'h0F0F_0F0F);
        send_item(smm_pkg::CMD_LOAD_B, 32'hF0F0_F0F0);
        change_size(4'd1);
        send_item(smm_pkg::CMD_LOAD_A, 32'h8000_0000);
        send_item(smm_pkg::CMD_LOAD_B, 32'h0000_0002);

        // Random phases: the largest code first (acts as the maximum size), then a
        // long receiver hold-off while several pairs queue up, then the exact maximum.
        phase = 0;
        while (product_sb.loads_used < ITEM_TARGET)
        begin
            if (phase == 0)
                size_val = 4'd15;
            else if (phase == 1)
                size_val = 4'd3;
            else if (phase == 2)
                size_val = 4'd8;
            else if ($urandom_range(0, 9) < 7)
                size_val = SIZE_W'($urandom_range(0, 4));
            else
                size_val = SIZE_W'($urandom_range(5, 15));
            change_size(size_val);
            send_burst = ($urandom_range(0, 3) == 0);
            if (phase == 0 || phase == 2)
                pairs = 1;
            else if (phase == 1)
                pairs = 3;
            else
                pairs = $urandom_range(1, 3);
            for (int unsigned p = 0; p < pairs; p++)
            begin
                if (product_sb.loads_used >= ITEM_TARGET)
                    break;
                if (phase == 1 && p == 0)
                    hold_cycles = HOLD_OFF_CYCLES;
                run_sequence();
            end
            phase++;
        end

        // Drain: wait for every predicted product, then a little longer for strays
        ld_if.valid <= 1'b0;
        while (product_sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        product_sb.flag_leftovers();
        if (product_sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
design/smm_pkg.sv
design/smm_load_if.sv
design/smm_result_if.sv
design/smm_cfg_if.sv
design/smm_ram.sv
design/smm_mac.sv
design/square_matrix_multiply.sv
dv/testbench.sv
